>>> hw/rtl/iucrc_pkg.sv
// shared constants and codes for the image update receiver
package iucrc_pkg;

  // request function codes
  localparam logic [2:0] FN_BEGIN      = 3'd0;
  localparam logic [2:0] FN_END        = 3'd1;
  localparam logic [2:0] FN_ABORT      = 3'd2;
  localparam logic [2:0] FN_HEADER     = 3'd3;
  localparam logic [2:0] FN_DATA       = 3'd4;
  localparam logic [2:0] FN_DISCONNECT = 3'd5;
  localparam logic [2:0] FN_TICK       = 3'd6;

  // phase and error codes
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_RECV  = 4'd1;
  localparam logic [3:0] PH_DONE  = 4'd2;
  localparam logic [3:0] ER_BEGIN = 4'd3;
  localparam logic [3:0] ER_SEQ   = 4'd4;
  localparam logic [3:0] ER_WRITE = 4'd5;
  localparam logic [3:0] ER_CRC   = 4'd6;
  localparam logic [3:0] ER_SIZE  = 4'd7;
  localparam logic [3:0] ER_END   = 4'd8;
  localparam logic [3:0] ER_NONE  = 4'd0;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam logic [15:0] REBOOT_DELAY_RESET = 16'd1500;
  localparam int unsigned MAX_CHUNK_DEFAULT  = 512;

endpackage

>>> hw/rtl/iucrc_if.sv
// valid/ready channel interfaces for requests, results and configuration
interface iucrc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  payload_byte;
  logic [9:0]  chunk_length;
  logic [31:0] image_size;
  logic [31:0] expected_crc;
  logic        begin_well_formed;
  logic        storage_ok;

  modport source (output valid, func, payload_byte, chunk_length, image_size,
                  expected_crc, begin_well_formed, storage_ok, input ready);
  modport sink (input valid, func, payload_byte, chunk_length, image_size,
                expected_crc, begin_well_formed, storage_ok, output ready);
endinterface

interface iucrc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  phase;
  logic [3:0]  error_code;
  logic [31:0] received_count;
  logic        notify;
  logic        active;
  logic        reboot_request;

  modport source (output valid, phase, error_code, received_count, notify, active,
                  reboot_request, input ready);
  modport sink (input valid, phase, error_code, received_count, notify, active,
                reboot_request, output ready);
endinterface

interface iucrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/iucrc_crc_byte.sv
// reflected crc-32 update by one byte, eight bit steps unrolled
module iucrc_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? iucrc_pkg::CRC_POLY : 32'd0);
    end
    crc_out = c;
  end

endmodule

>>> hw/rtl/image_update_receiver_crc32.sv
// image update receiver: request register, registered state update, result register
// a request waits in the request register, and its result is then registered in the result register
// throughput: one request per cycle while the result is not stalled; the byte-wide crc step sets the critical path
// reset (rst, synchronous): idle phase, counters clear, crc all ones, delay 1500
// a stalled result holds the update stage; the request register keeps taking input
// only while its own slot is free or moving on
module image_update_receiver_crc32 #(
  parameter int unsigned MAX_CHUNK = iucrc_pkg::MAX_CHUNK_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  iucrc_in_if.sink     in_ch,
  iucrc_out_if.source  out_ch,
  iucrc_cfg_if.sink    cfg_ch
);

  // chunk length field is 10 bits, so a chunk never exceeds 1023 bytes either
  localparam int unsigned CHUNK_CAP = (MAX_CHUNK < 1023) ? MAX_CHUNK : 1023;
  localparam int unsigned CW        = $clog2(CHUNK_CAP + 1);

  // ---------------- configuration ----------------
  logic [15:0] reboot_delay;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reboot_delay <= iucrc_pkg::REBOOT_DELAY_RESET;
    end else if (cfg_ch.valid) begin
      reboot_delay <= cfg_ch.data;
    end
  end

  // ---------------- request register ----------------
  logic        req_valid;
  logic [2:0]  req_func;
  logic [7:0]  req_byte;
  logic [9:0]  req_clen;
  logic [31:0] req_size;
  logic [31:0] req_crc;
  logic        req_wf;
  logic        req_ok;

  logic        step;       // request in register is processed this cycle
  logic        res_free;

  assign res_free    = !out_ch.valid || out_ch.ready;
  assign step        = req_valid && res_free;
  assign in_ch.ready = !req_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ch.ready) begin
      req_valid <= in_ch.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_func <= in_ch.func;
      req_byte <= in_ch.payload_byte;
      req_clen <= in_ch.chunk_length;
      req_size <= in_ch.image_size;
      req_crc  <= in_ch.expected_crc;
      req_wf   <= in_ch.begin_well_formed;
      req_ok   <= in_ch.storage_ok;
    end
  end

  // ---------------- receiver state ----------------
  logic [3:0]    phase_reg, phase_reg_next;
  logic [3:0]    error_reg, error_reg_next;
  logic [31:0]   size_reg, size_reg_next;
  logic [31:0]   target_crc, target_crc_next;
  logic [31:0]   byte_count, byte_count_next;
  logic [31:0]   running_crc, running_crc_next;
  logic [CW-1:0] chunk_remaining, chunk_remaining_next;
  logic [15:0]   reboot_countdown, reboot_countdown_next;
  logic          reboot_pending, reboot_pending_next;
  logic          notify_next;
  logic          pulse_next;

  logic [31:0] crc_stepped;
  logic [32:0] count_plus_len;
  logic        chunk_too_long;

  iucrc_crc_byte u_crc (
    .crc_in  (running_crc),
    .data    (req_byte),
    .crc_out (crc_stepped)
  );

  assign count_plus_len = {1'b0, byte_count} + {23'd0, req_clen};
  assign chunk_too_long = {22'd0, req_clen} > 32'(MAX_CHUNK);

  always_comb begin
    phase_reg_next        = phase_reg;
    error_reg_next        = error_reg;
    size_reg_next         = size_reg;
    target_crc_next       = target_crc;
    byte_count_next       = byte_count;
    running_crc_next      = running_crc;
    chunk_remaining_next  = chunk_remaining;
    reboot_countdown_next = reboot_countdown;
    reboot_pending_next   = reboot_pending;
    notify_next           = 1'b0;
    pulse_next            = 1'b0;

    case (req_func)
      iucrc_pkg::FN_BEGIN: begin
        notify_next           = 1'b1;
        reboot_pending_next   = 1'b0;
        reboot_countdown_next = 16'd0;
        chunk_remaining_next  = '0;
        if (!req_wf || !req_ok) begin
          phase_reg_next = iucrc_pkg::ER_BEGIN;
          error_reg_next = iucrc_pkg::ER_BEGIN;
        end else begin
          size_reg_next    = req_size;
          target_crc_next  = req_crc;
          byte_count_next  = 32'd0;
          running_crc_next = iucrc_pkg::CRC_ONES;
          error_reg_next   = iucrc_pkg::ER_NONE;
          phase_reg_next   = iucrc_pkg::PH_RECV;
        end
      end
      iucrc_pkg::FN_END: begin
        if (phase_reg == iucrc_pkg::PH_RECV) begin
          notify_next          = 1'b1;
          chunk_remaining_next = '0;
          if (byte_count != size_reg) begin
            phase_reg_next        = iucrc_pkg::ER_SIZE;
            error_reg_next        = iucrc_pkg::ER_SIZE;
            reboot_pending_next   = 1'b0;
            reboot_countdown_next = 16'd0;
          end else if (target_crc != 32'd0 &&
                       (running_crc ^ iucrc_pkg::CRC_ONES) != target_crc) begin
            phase_reg_next        = iucrc_pkg::ER_CRC;
            error_reg_next        = iucrc_pkg::ER_CRC;
            reboot_pending_next   = 1'b0;
            reboot_countdown_next = 16'd0;
          end else if (!req_ok) begin
            phase_reg_next        = iucrc_pkg::ER_END;
            error_reg_next        = iucrc_pkg::ER_END;
            reboot_pending_next   = 1'b0;
            reboot_countdown_next = 16'd0;
          end else begin
            phase_reg_next        = iucrc_pkg::PH_DONE;
            error_reg_next        = iucrc_pkg::ER_NONE;
            reboot_pending_next   = 1'b1;
            reboot_countdown_next = reboot_delay;
          end
        end
      end
      iucrc_pkg::FN_ABORT: begin
        notify_next           = 1'b1;
        phase_reg_next        = iucrc_pkg::PH_IDLE;
        error_reg_next        = iucrc_pkg::ER_NONE;
        byte_count_next       = 32'd0;
        reboot_pending_next   = 1'b0;
        reboot_countdown_next = 16'd0;
        chunk_remaining_next  = '0;
      end
      iucrc_pkg::FN_HEADER: begin
        // any partly received chunk is dropped
        chunk_remaining_next = '0;
        if (phase_reg != iucrc_pkg::PH_RECV) begin
          notify_next           = 1'b1;
          phase_reg_next        = iucrc_pkg::ER_SEQ;
          error_reg_next        = iucrc_pkg::ER_SEQ;
          reboot_pending_next   = 1'b0;
          reboot_countdown_next = 16'd0;
        end else if (req_clen != 10'd0) begin
          if (chunk_too_long || count_plus_len > {1'b0, size_reg}) begin
            notify_next    = 1'b1;
            phase_reg_next = iucrc_pkg::ER_SIZE;
            error_reg_next = iucrc_pkg::ER_SIZE;
            reboot_pending_next   = 1'b0;
            reboot_countdown_next = 16'd0;
          end else if (!req_ok) begin
            notify_next    = 1'b1;
            phase_reg_next = iucrc_pkg::ER_WRITE;
            error_reg_next = iucrc_pkg::ER_WRITE;
            reboot_pending_next   = 1'b0;
            reboot_countdown_next = 16'd0;
          end else begin
            chunk_remaining_next = CW'(req_clen);
          end
        end
      end
      iucrc_pkg::FN_DATA: begin
        if (phase_reg == iucrc_pkg::PH_RECV && chunk_remaining != '0) begin
          running_crc_next     = crc_stepped;
          byte_count_next      = byte_count + 32'd1;
          chunk_remaining_next = chunk_remaining - CW'(1);
        end
      end
      iucrc_pkg::FN_DISCONNECT: begin
        if (phase_reg == iucrc_pkg::PH_RECV) begin
          notify_next           = 1'b1;
          phase_reg_next        = iucrc_pkg::PH_IDLE;
          error_reg_next        = iucrc_pkg::ER_NONE;
          byte_count_next       = 32'd0;
          reboot_pending_next   = 1'b0;
          reboot_countdown_next = 16'd0;
          chunk_remaining_next  = '0;
        end
      end
      iucrc_pkg::FN_TICK: begin
        if (phase_reg == iucrc_pkg::PH_DONE && reboot_pending) begin
          // a delay of zero behaves like one tick
          if (reboot_countdown <= 16'd1) begin
            reboot_countdown_next = 16'd0;
            reboot_pending_next   = 1'b0;
            pulse_next            = 1'b1;
          end else begin
            reboot_countdown_next = reboot_countdown - 16'd1;
          end
        end
      end
      default: begin
        // unused function code: no change, quiet result
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg        <= iucrc_pkg::PH_IDLE;
      error_reg        <= iucrc_pkg::ER_NONE;
      size_reg         <= 32'd0;
      target_crc       <= 32'd0;
      byte_count       <= 32'd0;
      running_crc      <= iucrc_pkg::CRC_ONES;
      chunk_remaining  <= '0;
      reboot_countdown <= 16'd0;
      reboot_pending   <= 1'b0;
    end else if (step) begin
      phase_reg        <= phase_reg_next;
      error_reg        <= error_reg_next;
      size_reg         <= size_reg_next;
      target_crc       <= target_crc_next;
      byte_count       <= byte_count_next;
      running_crc      <= running_crc_next;
      chunk_remaining  <= chunk_remaining_next;
      reboot_countdown <= reboot_countdown_next;
      reboot_pending   <= reboot_pending_next;
    end
  end

  // ---------------- result register ----------------
  logic res_valid;

  assign out_ch.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_ch.phase          <= phase_reg_next;
      out_ch.error_code     <= error_reg_next;
      out_ch.received_count <= byte_count_next;
      out_ch.notify         <= notify_next;
      out_ch.active         <= (phase_reg_next == iucrc_pkg::PH_RECV) ||
                               (phase_reg_next == iucrc_pkg::PH_DONE && reboot_pending_next);
      out_ch.reboot_request <= pulse_next;
    end
  end

endmodule
